// File: design/ordered_array_list_engine_defines.svh
// Assertion macros used by the checker file of the ordered array list engine.
`ifndef ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define ORDERED_ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OALE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OALE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/oale_pkg.sv
// Types, codes and constants shared by the ordered array list engine.
`timescale 1ns / 1ps
package oale_pkg;

  localparam int unsigned DEPTH_DEF = 32;
  localparam int unsigned IDX_W     = 7;

  typedef logic [IDX_W-1:0] idx_t;

  localparam logic [2:0] CMD_INSERT  = 3'd0;
  localparam logic [2:0] CMD_DELETE  = 3'd1;
  localparam logic [2:0] CMD_SEARCH  = 3'd2;
  localparam logic [2:0] CMD_UPDATE  = 3'd3;
  localparam logic [2:0] CMD_DISPLAY = 3'd4;
  localparam logic [2:0] CMD_SORT    = 3'd5;
  localparam logic [2:0] CMD_REVERSE = 3'd6;

  localparam logic [2:0] STAT_OK    = 3'd0;
  localparam logic [2:0] STAT_FULL  = 3'd1;
  localparam logic [2:0] STAT_RANGE = 3'd2;
  localparam logic [2:0] STAT_EMPTY = 3'd3;
  localparam logic [2:0] STAT_MISS  = 3'd4;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [5:0]         position;
    logic signed [31:0] operand_value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [4:0]         result_index;
    logic signed [31:0] result_value;
    logic [5:0]         entry_count;
    logic               last;
  } rsp_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_LOAD,
    CELL_ROTATE,
    CELL_SORT
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    idx_t               pos;
    idx_t               limit;
    logic               parity;
    logic signed [31:0] value;
  } cell_ctl_t;

endpackage

// File: design/ordered_array_list_engine.sv
// Top level of the ordered array list engine: command sequencer over a chain of cells.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o  in_req_i  (cmd, position, operand_value)
//   out      output     out_valid_o/out_stall_i out_rsp_o (status .. last)
//
// Insert, delete, update, refused commands, and sort or reverse below two entries load their
// result on acceptance. Search steps the chain once per entry, sort and reverse do so from two
// entries up, and a done state then loads the result once the output is free.
// Display moves the list one cell per delivered result, so output stalls hold it.
// The input stalls while a command is in progress or a result is blocked.
// Reset clears the count and the control state; the entry cells are not cleared.
`timescale 1ns / 1ps
module ordered_array_list_engine #(
  parameter int unsigned DEPTH = oale_pkg::DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  oale_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output oale_pkg::rsp_t out_rsp_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [2:0]         op_q, op_d;
  logic [CW-1:0]      step_q, step_d;
  logic [CW-1:0]      count_q, count_d;
  logic signed [31:0] key_q, key_d;
  logic               hit_q, hit_d;
  logic [CW-1:0]      hit_idx_q, hit_idx_d;
  logic               out_valid_q;
  oale_pkg::rsp_t     out_rsp_q, rsp_d;

  logic               load;
  logic               out_free;
  logic               accept;
  logic               last_step;
  logic               step_adv;
  oale_pkg::idx_t     count_x, pos_x, step_x, hit_x, cnt_new;
  oale_pkg::cell_ctl_t ctl;

  logic signed [31:0] cell_val [DEPTH];
  logic signed [31:0] left_val [DEPTH];
  logic signed [31:0] right_val[DEPTH];
  logic               swap_r   [DEPTH];
  logic               swap_l   [DEPTH];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign count_x    = oale_pkg::idx_t'(count_q);
  assign pos_x      = oale_pkg::idx_t'(in_req_i.position);
  assign step_x     = oale_pkg::idx_t'(step_q);
  assign hit_x      = oale_pkg::idx_t'(hit_idx_q);
  assign last_step  = (step_q == (count_q - CW'(1)));
  assign step_adv   = (op_q == oale_pkg::CMD_DISPLAY) ? out_free : 1'b1;
  assign cnt_new    = oale_pkg::idx_t'(count_d);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    step_d    = step_q;
    count_d   = count_q;
    key_d     = key_q;
    hit_d     = hit_q;
    hit_idx_d = hit_idx_q;
    load      = 1'b0;
    rsp_d     = '0;
    ctl.op     = oale_pkg::CELL_HOLD;
    ctl.pos    = pos_x;
    ctl.limit  = count_x;
    ctl.parity = step_q[0];
    ctl.value  = in_req_i.operand_value;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d      = in_req_i.cmd;
          key_d     = in_req_i.operand_value;
          step_d    = '0;
          hit_d     = 1'b0;
          hit_idx_d = '0;
          rsp_d.last   = 1'b1;
          rsp_d.status = oale_pkg::STAT_OK;
          load         = 1'b1;
          unique case (in_req_i.cmd)
            oale_pkg::CMD_INSERT: begin
              if (count_x >= oale_pkg::idx_t'(DEPTH)) begin
                rsp_d.status = oale_pkg::STAT_FULL;
              end else if (pos_x > count_x) begin
                rsp_d.status = oale_pkg::STAT_RANGE;
              end else begin
                ctl.op  = oale_pkg::CELL_INSERT;
                count_d = count_q + CW'(1);
              end
            end
            oale_pkg::CMD_DELETE: begin
              if (count_q == '0) begin
                rsp_d.status = oale_pkg::STAT_EMPTY;
              end else if (pos_x >= count_x) begin
                rsp_d.status = oale_pkg::STAT_RANGE;
              end else begin
                ctl.op  = oale_pkg::CELL_DELETE;
                count_d = count_q - CW'(1);
              end
            end
            oale_pkg::CMD_UPDATE: begin
              if (pos_x >= count_x) begin
                rsp_d.status = oale_pkg::STAT_RANGE;
              end else begin
                ctl.op = oale_pkg::CELL_LOAD;
              end
            end
            oale_pkg::CMD_SEARCH: begin
              if (count_q == '0) begin
                rsp_d.status = oale_pkg::STAT_MISS;
              end else begin
                load    = 1'b0;
                state_d = S_WALK;
              end
            end
            oale_pkg::CMD_DISPLAY: begin
              if (count_q == '0) begin
                rsp_d.status = oale_pkg::STAT_EMPTY;
              end else begin
                load    = 1'b0;
                state_d = S_WALK;
              end
            end
            oale_pkg::CMD_SORT, oale_pkg::CMD_REVERSE: begin
              if (count_x >= oale_pkg::idx_t'(2)) begin
                load    = 1'b0;
                state_d = S_WALK;
              end
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
      end
      S_WALK: begin
        if (step_adv) begin
          ctl.op = (op_q == oale_pkg::CMD_SORT) ? oale_pkg::CELL_SORT
                                                : oale_pkg::CELL_ROTATE;
          if (op_q == oale_pkg::CMD_REVERSE) begin
            ctl.limit = count_x - step_x;
          end
          if ((op_q == oale_pkg::CMD_SEARCH) && !hit_q && (cell_val[0] == key_q)) begin
            hit_d     = 1'b1;
            hit_idx_d = step_q;
          end
          if (op_q == oale_pkg::CMD_DISPLAY) begin
            load               = 1'b1;
            rsp_d.status       = oale_pkg::STAT_OK;
            rsp_d.result_index = step_x[4:0];
            rsp_d.result_value = cell_val[0];
            rsp_d.last         = last_step;
          end
          if (last_step) begin
            state_d = (op_q == oale_pkg::CMD_DISPLAY) ? S_IDLE : S_DONE;
          end else begin
            step_d = step_q + CW'(1);
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          load       = 1'b1;
          rsp_d.last = 1'b1;
          if ((op_q == oale_pkg::CMD_SEARCH) && !hit_q) begin
            rsp_d.status = oale_pkg::STAT_MISS;
          end else begin
            rsp_d.status       = oale_pkg::STAT_OK;
            rsp_d.result_index = hit_x[4:0];
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rsp_d.entry_count = cnt_new[5:0];
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_val[g] = '0;
      assign swap_l[g]   = 1'b0;
    end else begin : g_inner
      assign left_val[g] = cell_val[g-1];
      assign swap_l[g]   = swap_r[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_val[g] = '0;
    end else begin : g_mid
      assign right_val[g] = cell_val[g+1];
    end

    oale_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .idx_i    (oale_pkg::idx_t'(g)),
      .left_i   (left_val[g]),
      .right_i  (right_val[g]),
      .head_i   (cell_val[0]),
      .swap_l_i (swap_l[g]),
      .val_o    (cell_val[g]),
      .swap_r_o (swap_r[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= oale_pkg::CMD_INSERT;
      step_q      <= '0;
      count_q     <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      step_q    <= step_d;
      count_q   <= count_d;
      hit_q     <= hit_d;
      hit_idx_q <= hit_idx_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (load) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// File: design/oale_cell.sv
// One list cell: holds a single entry and exchanges it with its neighbors.
`timescale 1ns / 1ps
module oale_cell (
  input  logic                clk_i,
  input  oale_pkg::cell_ctl_t ctl_i,
  input  oale_pkg::idx_t      idx_i,
  input  logic signed [31:0]  left_i,
  input  logic signed [31:0]  right_i,
  input  logic signed [31:0]  head_i,
  input  logic                swap_l_i,
  output logic signed [31:0]  val_o,
  output logic                swap_r_o
);

  logic signed [31:0] val_q, val_d;
  oale_pkg::idx_t     nxt;

  assign nxt = idx_i + oale_pkg::idx_t'(1);

  assign swap_r_o = (ctl_i.op == oale_pkg::CELL_SORT) && (idx_i[0] == ctl_i.parity) &&
                    (nxt < ctl_i.limit) && (val_q > right_i);

  always_comb begin
    val_d = val_q;
    unique case (ctl_i.op)
      oale_pkg::CELL_INSERT: begin
        if (idx_i == ctl_i.pos) begin
          val_d = ctl_i.value;
        end else if (idx_i > ctl_i.pos) begin
          val_d = left_i;
        end
      end
      oale_pkg::CELL_DELETE: begin
        if (idx_i >= ctl_i.pos) begin
          val_d = right_i;
        end
      end
      oale_pkg::CELL_LOAD: begin
        if (idx_i == ctl_i.pos) begin
          val_d = ctl_i.value;
        end
      end
      oale_pkg::CELL_ROTATE: begin
        if (nxt < ctl_i.limit) begin
          val_d = right_i;
        end else if (nxt == ctl_i.limit) begin
          val_d = head_i;
        end
      end
      oale_pkg::CELL_SORT: begin
        if (swap_r_o) begin
          val_d = right_i;
        end else if (swap_l_i) begin
          val_d = left_i;
        end
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// File: design/oale_checker.sv
// Port-level checker for the ordered array list engine and its bind.
`timescale 1ns / 1ps
`include "ordered_array_list_engine_defines.svh"
module oale_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input oale_pkg::rsp_t out_rsp_o
);

  `OALE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o), "Stalled result changed or dropped.")
  `OALE_ASSERT_NOW(a_accept_free, in_valid_i && !in_stall_o, !(out_valid_o && out_stall_i), "Request taken while a result is blocked.")
  `OALE_ASSERT_NOW(a_empty_count, out_valid_o && (out_rsp_o.status == oale_pkg::STAT_EMPTY), out_rsp_o.entry_count == 6'd0, "Empty status with nonzero count.")
  `OALE_ASSERT_NOW(a_fail_value, out_valid_o && (out_rsp_o.status != oale_pkg::STAT_OK), out_rsp_o.result_value == 32'sd0 && out_rsp_o.last, "Failed request carries data or is not final.")
  `OALE_ASSERT_NOW(a_mid_ok, out_valid_o && !out_rsp_o.last, out_rsp_o.status == oale_pkg::STAT_OK, "Non-final result without ok status.")

endmodule

bind ordered_array_list_engine oale_checker u_oale_checker (.*);
